@@ hw/rtl/gtsa_pkg.sv @@
// Shared types and constants of the generation-tagged slot allocator.
package gtsa_pkg;

   localparam int IDX_W = 8;
   localparam int GEN_W = 16;

   localparam logic        ACTION_CLAIM   = 1'b0;
   localparam logic        ACTION_DONE    = 1'b1;

   localparam logic [2:0]  STATUS_CLAIMED     = 3'd0;
   localparam logic [2:0]  STATUS_NO_SLOT     = 3'd1;
   localparam logic [2:0]  STATUS_NO_LISTENER = 3'd2;
   localparam logic [2:0]  STATUS_FREED       = 3'd3;
   localparam logic [2:0]  STATUS_INVALID     = 3'd4;
   localparam logic [2:0]  STATUS_STALE       = 3'd5;

   localparam logic        CSR_SLOTS_IN_USE     = 1'b0;
   localparam logic        CSR_LISTENER_PRESENT = 1'b1;

   localparam logic [31:0] HANDLE_INVALID = 32'hffff_ffff;

   typedef struct packed {
      logic        action;
      logic [5:0]  voice;
      logic [31:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [31:0] handle_out;
      logic [5:0]  slot_index;
      logic [2:0]  status;
      logic        notify;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [5:0]       wr_owner;
      logic [GEN_W-1:0] wr_gen;
      logic             set_active;
      logic             clr_active;
      logic [IDX_W-1:0] act_addr;
   } slot_cmd_type;

   typedef struct packed {
      logic             active;
      logic [5:0]       owner;
      logic [GEN_W-1:0] gen;
   } slot_rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_slot;
      logic             clr_en;
      logic [IDX_W-1:0] clr_addr;
   } map_cmd_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] slot;
   } map_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REL,
      ST_GEN_TRY,
      ST_GEN_SCAN,
      ST_CLAIM_WR,
      ST_CLAIM_NONE,
      ST_DONE_MAP,
      ST_DONE_SLOT,
      ST_DONE_CHECK
   } state_type;

endpackage

@@ hw/rtl/gtsa_slot_store.sv @@
// Slot store: owner and generation memory plus per-slot active flags.
module gtsa_slot_store
   import gtsa_pkg::*;
#(
   parameter int NUM_SLOTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  slot_cmd_type cmd,
   output slot_rsp_type rsp
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [5+GEN_W:0]     mem_ff [NUM_SLOTS];
   logic [5+GEN_W:0]     rd_data_ff;
   logic [SW-1:0]        rd_addr_ff;
   logic [NUM_SLOTS-1:0] active_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[SW'(cmd.wr_addr)] <= {cmd.wr_owner, cmd.wr_gen};
      end
      rd_data_ff <= mem_ff[SW'(cmd.rd_addr)];
      rd_addr_ff <= SW'(cmd.rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.set_active) begin
         active_ff[SW'(cmd.act_addr)] <= 1'b1;
      end else if (cmd.clr_active) begin
         active_ff[SW'(cmd.act_addr)] <= 1'b0;
      end
   end

   assign rsp.active = active_ff[rd_addr_ff];
   assign rsp.owner  = rd_data_ff[5+GEN_W:GEN_W];
   assign rsp.gen    = rd_data_ff[GEN_W-1:0];

endmodule

@@ hw/rtl/gtsa_voice_map.sv @@
// Voice map: voice to slot memory with per-voice valid flags.
module gtsa_voice_map
   import gtsa_pkg::*;
#(
   parameter int NUM_VOICES = 64,
   parameter int NUM_SLOTS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  map_cmd_type cmd,
   output map_rsp_type rsp
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   logic [SW-1:0]         mem_ff [NUM_VOICES];
   logic [SW-1:0]         rd_data_ff;
   logic [VW-1:0]         rd_addr_ff;
   logic [NUM_VOICES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[VW'(cmd.wr_addr)] <= SW'(cmd.wr_slot);
      end
      rd_data_ff <= mem_ff[VW'(cmd.rd_addr)];
      rd_addr_ff <= VW'(cmd.rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[VW'(cmd.wr_addr)] <= 1'b1;
      end else if (cmd.clr_en) begin
         valid_ff[VW'(cmd.clr_addr)] <= 1'b0;
      end
   end

   assign rsp.valid = valid_ff[rd_addr_ff];
   assign rsp.slot  = IDX_W'(rd_data_ff);

endmodule

@@ hw/rtl/gtsa_ctrl.sv @@
// Sequencer: release scan, generation search, done lookup and result register.
module gtsa_ctrl
   import gtsa_pkg::*;
#(
   parameter int NUM_VOICES = 64,
   parameter int NUM_SLOTS  = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   input  logic [6:0]   slots_in_use,
   input  logic         listener_present,
   output slot_cmd_type slot_cmd,
   input  slot_rsp_type slot_rsp,
   output map_cmd_type  map_cmd,
   input  map_rsp_type  map_rsp,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   state_type        state_ff, state_in;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_load;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic             issue_ff, issue_in;
   logic             cmp_v_ff, cmp_v_in;
   logic [SW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             found_ff;
   logic [SW-1:0]    sb_ff;
   logic [GEN_W-1:0] gen_ff;
   logic [GEN_W-1:0] next_gen_ff;
   logic             scan_start, scan_stop;
   logic             accept;
   logic [8:0]       lim, lim_last;
   logic             in_voice_ok, in_handle_ok;
   logic             owner_match, hit, freeable, last_cmp, clash, gen_match, owner_ok;

   assign lim      = (9'(slots_in_use) > 9'(NUM_SLOTS)) ? 9'(NUM_SLOTS) : 9'(slots_in_use);
   assign lim_last = lim - 9'd1;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign in_voice_ok  = 9'(req_data.voice) < 9'(NUM_VOICES);
   assign in_handle_ok = (req_data.handle_in != HANDLE_INVALID)
                         && (9'(req_data.handle_in[7:0]) < 9'(NUM_VOICES));

   assign owner_match = (slot_rsp.owner == req_ff.voice);
   assign hit         = cmp_v_ff && slot_rsp.active && owner_match;
   assign freeable    = cmp_v_ff && (!slot_rsp.active || owner_match);
   assign last_cmp    = cmp_v_ff && (9'(cmp_idx_ff) == lim_last);
   assign clash       = cmp_v_ff && (cmp_idx_ff != sb_ff) && slot_rsp.active
                        && (slot_rsp.gen == gen_ff);
   assign gen_match   = (slot_rsp.gen == req_ff.handle_in[8+GEN_W-1:8]);
   assign owner_ok    = 9'(slot_rsp.owner) < 9'(NUM_VOICES);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACTION_CLAIM) begin
                  if (in_voice_ok) begin
                     state_in = (lim == 9'd0) ? ST_CLAIM_NONE : ST_REL;
                  end
               end else if (in_handle_ok) begin
                  state_in = ST_DONE_MAP;
               end
            end
         end
         ST_REL: begin
            if (last_cmp) begin
               state_in = (found_ff || freeable) ? ST_GEN_TRY : ST_CLAIM_NONE;
            end
         end
         ST_GEN_TRY: state_in = ST_GEN_SCAN;
         ST_GEN_SCAN: begin
            if (clash) begin
               state_in = ST_GEN_TRY;
            end else if (last_cmp) begin
               state_in = ST_CLAIM_WR;
            end
         end
         ST_CLAIM_WR:   state_in = ST_IDLE;
         ST_CLAIM_NONE: state_in = ST_IDLE;
         ST_DONE_MAP:   state_in = ST_DONE_SLOT;
         ST_DONE_SLOT:  state_in = map_rsp.valid ? ST_DONE_CHECK : ST_IDLE;
         ST_DONE_CHECK: state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      slot_cmd   = '0;
      map_cmd    = '0;
      rsp_load   = 1'b0;
      rsp_in     = '{handle_out: HANDLE_INVALID, slot_index: 6'd0,
                     status: STATUS_NO_SLOT, notify: 1'b0};
      scan_start = 1'b0;
      scan_stop  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACTION_CLAIM) begin
                  if (in_voice_ok) begin
                     scan_start = (lim != 9'd0);
                  end else begin
                     rsp_load = 1'b1;
                  end
               end else if (!in_handle_ok) begin
                  rsp_load          = 1'b1;
                  rsp_in.handle_out = req_data.handle_in;
                  rsp_in.status     = STATUS_INVALID;
               end
            end
         end
         ST_REL: begin
            slot_cmd.rd_addr    = IDX_W'(cnt_ff);
            slot_cmd.clr_active = hit;
            slot_cmd.act_addr   = IDX_W'(cmp_idx_ff);
         end
         ST_GEN_TRY: begin
            scan_start = 1'b1;
         end
         ST_GEN_SCAN: begin
            slot_cmd.rd_addr = IDX_W'(cnt_ff);
            scan_stop        = clash;
         end
         ST_CLAIM_WR: begin
            slot_cmd.wr_en      = 1'b1;
            slot_cmd.wr_addr    = IDX_W'(sb_ff);
            slot_cmd.wr_owner   = req_ff.voice;
            slot_cmd.wr_gen     = gen_ff;
            slot_cmd.set_active = 1'b1;
            slot_cmd.act_addr   = IDX_W'(sb_ff);
            map_cmd.wr_en       = 1'b1;
            map_cmd.wr_addr     = IDX_W'(req_ff.voice);
            map_cmd.wr_slot     = IDX_W'(sb_ff);
            rsp_load            = 1'b1;
            rsp_in.slot_index   = 6'(sb_ff);
            if (listener_present) begin
               rsp_in.handle_out = {8'h00, gen_ff, 2'b00, req_ff.voice};
               rsp_in.status     = STATUS_CLAIMED;
               rsp_in.notify     = 1'b1;
            end else begin
               rsp_in.status     = STATUS_NO_LISTENER;
            end
         end
         ST_CLAIM_NONE: begin
            map_cmd.clr_en   = 1'b1;
            map_cmd.clr_addr = IDX_W'(req_ff.voice);
            rsp_load         = 1'b1;
         end
         ST_DONE_MAP: begin
            map_cmd.rd_addr = req_ff.handle_in[IDX_W-1:0];
         end
         ST_DONE_SLOT: begin
            slot_cmd.rd_addr = map_rsp.slot;
            if (!map_rsp.valid) begin
               rsp_load          = 1'b1;
               rsp_in.handle_out = req_ff.handle_in;
               rsp_in.status     = STATUS_INVALID;
            end
         end
         ST_DONE_CHECK: begin
            rsp_load          = 1'b1;
            rsp_in.handle_out = req_ff.handle_in;
            if (gen_match) begin
               slot_cmd.clr_active = 1'b1;
               slot_cmd.act_addr   = IDX_W'(sb_ff);
               map_cmd.clr_en      = owner_ok;
               map_cmd.clr_addr    = IDX_W'(slot_rsp.owner);
               rsp_in.slot_index   = 6'(sb_ff);
               rsp_in.status       = STATUS_FREED;
               rsp_in.notify       = listener_present;
            end else begin
               rsp_in.status       = STATUS_STALE;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in     = cnt_ff;
      issue_in   = 1'b0;
      cmp_v_in   = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      if (scan_start) begin
         cnt_in   = '0;
         issue_in = 1'b1;
      end else if (!scan_stop && (state_ff == ST_REL || state_ff == ST_GEN_SCAN)) begin
         cmp_v_in   = issue_ff;
         cmp_idx_in = cnt_ff;
         if (issue_ff) begin
            cnt_in   = cnt_ff + SW'(1);
            issue_in = (9'(cnt_ff) != lim_last);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         cmp_v_ff     <= 1'b0;
         found_ff     <= 1'b0;
         next_gen_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load;
         issue_ff     <= issue_in;
         cmp_v_ff     <= cmp_v_in;
         if (accept) begin
            found_ff <= 1'b0;
         end else if (state_ff == ST_REL && freeable) begin
            found_ff <= 1'b1;
         end
         if (state_ff == ST_GEN_TRY) begin
            next_gen_ff <= next_gen_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      cmp_idx_ff <= cmp_idx_in;
      if (accept) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (state_ff == ST_GEN_TRY) begin
         gen_ff <= next_gen_ff;
      end
      if (state_ff == ST_REL && freeable && !found_ff) begin
         sb_ff <= cmp_idx_ff;
      end else if (state_ff == ST_DONE_SLOT) begin
         sb_ff <= SW'(map_rsp.slot);
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while sequencer busy");

   a_finish_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && (state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("item finished without a result");

   a_cmp_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmp_v_ff |-> (9'(cmp_idx_ff) < lim))
      else $error("scan compare beyond slot limit");

   a_claim_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_TRY) || (state_ff == ST_CLAIM_WR) |-> found_ff)
      else $error("generation search without a chosen slot");

   a_gen_counter_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_GEN_TRY) |=> $stable(next_gen_ff))
      else $error("generation counter moved outside a try");

endmodule

@@ hw/rtl/generation_tagged_slot_allocator.sv @@
// Top level of the generation-tagged slot allocator: CSRs, slot store, voice map, sequencer.
//
//   channel   ports                                     direction  handshake
//   req       start, busy, req_data                     in         start & !busy
//   rsp       rsp_strobe, rsp_data                      out        strobe, one cycle
//   csr       csr_valid, csr_ready, csr_index, csr_wdata in        valid & ready
//
// Done: an invalid handle is answered from idle; else the voice map is read, then the slot
// store unless unmapped. Claim: a release scan over the L effective slots, then generation
// tries, each rescanning them (a clash ends a try early); no free slot or L = 0 skips tries.
// Reset is synchronous and clears the active flags, voice map valid flags, generation
// counter and CSRs. The result strobes in the first cycle with busy low and cannot be
// held off; the next item may start in that same cycle.
module generation_tagged_slot_allocator
   import gtsa_pkg::*;
#(
   parameter int NUM_VOICES = 64,
   parameter int NUM_SLOTS  = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   logic [6:0]   slots_in_use_ff;
   logic         listener_present_ff;
   slot_cmd_type slot_cmd;
   slot_rsp_type slot_rsp;
   map_cmd_type  map_cmd;
   map_rsp_type  map_rsp;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff     <= '0;
         listener_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLOTS_IN_USE:     slots_in_use_ff     <= csr_wdata;
            CSR_LISTENER_PRESENT: listener_present_ff <= csr_wdata[0];
            default:              slots_in_use_ff     <= slots_in_use_ff;
         endcase
      end
   end

   gtsa_slot_store #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_slot_store (
      .clock (clock),
      .reset (reset),
      .cmd   (slot_cmd),
      .rsp   (slot_rsp)
   );

   gtsa_voice_map #(
      .NUM_VOICES (NUM_VOICES),
      .NUM_SLOTS  (NUM_SLOTS)
   ) u_voice_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .rsp   (map_rsp)
   );

   gtsa_ctrl #(
      .NUM_VOICES (NUM_VOICES),
      .NUM_SLOTS  (NUM_SLOTS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .slots_in_use     (slots_in_use_ff),
      .listener_present (listener_present_ff),
      .slot_cmd         (slot_cmd),
      .slot_rsp         (slot_rsp),
      .map_cmd          (map_cmd),
      .map_rsp          (map_rsp),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data)
   );

endmodule
